### rtl/cqe_pkg.sv
`timescale 1ns / 1ps

package cqe_pkg;

    localparam int DEPTH   = 64;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int CFG_W   = 7;
    localparam int DATA_W  = 32;
    localparam int CMDQ_N  = 2;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_DISP = 2'd2
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // clamp written capacity to 1..DEPTH
    function automatic logic [CW-1:0] eff_cap(input logic [CFG_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (v > CFG_W'(DEPTH)) begin
            r = CW'(DEPTH);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] ring_adv(input logic [AW-1:0] idx,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = CW'(idx) + CW'(1);
        return (nxt >= cap) ? '0 : nxt[AW-1:0];
    endfunction

endpackage

### rtl/cqe_ram.sv
`timescale 1ns / 1ps

module cqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cqe_front.sv
`timescale 1ns / 1ps

module cqe_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       i_command,
    input  logic signed [cqe_pkg::DATA_W-1:0] i_value,
    output logic                             o_cmd_valid,
    output cqe_pkg::t_cmd                    o_cmd,
    input  logic                             i_cmd_take
);
    import cqe_pkg::*;

    localparam int PW = $clog2(CMDQ_N);

    t_cmd          r_q [CMDQ_N];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_cnt;
    logic          w_store;
    logic          w_take;
    t_cmd          w_cmd;

    // unused command code is swallowed here
    always_comb begin
        w_cmd.value = i_value;
        w_cmd.op    = OP_ENQ;
        w_store     = 1'b0;
        case (i_command)
            OP_ENQ: begin
                w_cmd.op = OP_ENQ;
                w_store  = push && !full;
            end
            OP_DEQ: begin
                w_cmd.op = OP_DEQ;
                w_store  = push && !full;
            end
            OP_DISP: begin
                w_cmd.op = OP_DISP;
                w_store  = push && !full;
            end
            default: begin
                w_store = 1'b0;
            end
        endcase
    end

    assign full        = (r_cnt == (PW+1)'(CMDQ_N));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign w_take      = o_cmd_valid && i_cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_store) begin
                r_q[r_wptr] <= w_cmd;
                r_wptr      <= r_wptr + PW'(1);
            end
            if (w_take) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({w_store, w_take})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/cqe_back.sv
`timescale 1ns / 1ps

module cqe_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cqe_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_cmd_valid,
    input  cqe_pkg::t_cmd                     i_cmd,
    output logic                              o_cmd_take,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic signed [cqe_pkg::DATA_W-1:0] o_data,
    output logic                              o_last
);
    import cqe_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_walk, n_walk;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_left, n_left;
    logic [CW-1:0]      r_cap, n_cap;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    logic [DATA_W-1:0]  r_out_data, n_out_data;
    logic               r_out_last, n_out_last;

    logic               w_out_free;
    logic               w_take;
    logic               w_we;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [DATA_W-1:0]  w_rdata;

    cqe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_out_valid || pop;
    assign w_take     = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign o_cmd_take = w_take;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_walk       = r_walk;
        n_count      = r_count;
        n_left       = r_left;
        n_cap        = r_cap;
        n_out_valid  = r_out_valid && !pop;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_raddr      = r_head;

        if (w_take) begin
            case (i_cmd.op)
                OP_ENQ: begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_last  = 1'b1;
                    if (r_count >= r_cap) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_out_status = ST_OK;
                        w_we         = 1'b1;
                        n_tail       = ring_adv(r_tail, r_cap);
                        n_count      = r_count + CW'(1);
                    end
                end
                OP_DEQ, OP_DISP: begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                        n_out_data   = '0;
                        n_out_last   = 1'b1;
                    end else begin
                        w_re    = 1'b1;
                        n_state = S_READ;
                        if (i_cmd.op == OP_DEQ) begin
                            n_head  = ring_adv(r_head, r_cap);
                            n_count = r_count - CW'(1);
                            n_left  = CW'(1);
                        end else begin
                            n_walk = ring_adv(r_head, r_cap);
                            n_left = r_count;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end else if (r_state == S_READ && w_out_free) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_data   = w_rdata;
            n_out_last   = (r_left == CW'(1));
            n_left       = r_left - CW'(1);
            if (r_left == CW'(1)) begin
                n_state = S_IDLE;
            end else begin
                w_re    = 1'b1;
                w_raddr = r_walk;
                n_walk  = ring_adv(r_walk, r_cap);
            end
        end

        // capacity write also empties the queue
        if (i_cfg_we) begin
            n_cap   = eff_cap(i_cfg_wdata);
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_walk      <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_cap       <= CW'(DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_walk      <= n_walk;
            r_count     <= n_count;
            r_left      <= n_left;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign empty    = !r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("entry count beyond capacity");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap != '0 && r_cap <= CW'(DEPTH))
        else $error("effective capacity out of range");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_head == r_tail)
        else $error("empty queue with head and tail apart");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_left != '0 && r_left <= r_count + CW'(1))
        else $error("read walk with bad remaining count");
`endif

endmodule

### rtl/circular_queue_engine.sv
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// command   push / full             i_command, i_value
// result    empty / pop             o_status, o_data, o_last
// config    i_cfg_we                i_cfg_wdata (capacity, write also empties the queue)
//
// Enqueue answers without a store read; dequeue and display use the registered
// store read port, and display yields one entry per cycle unless the result stalls.
// A 2-deep command queue lets commands land while the back end is busy.
// Synchronous active-low reset; store contents are not cleared, no sweep needed.
// A stalled result holds the back end; commands keep landing until full.

module circular_queue_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_command,
    input  logic signed [cqe_pkg::DATA_W-1:0] i_value,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic signed [cqe_pkg::DATA_W-1:0] o_data,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [cqe_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import cqe_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_take;
    t_cmd w_cmd;

    cqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_command   (i_command),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    cqe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cqe_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE = 24;
    localparam int QUIET_TAIL = 30;

    typedef enum logic [1:0] {
        K_CMD,
        K_CFG,
        K_DRAIN
    } t_kind;

    typedef struct {
        t_kind                    kind;
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] val;
        logic [CFG_W-1:0]         cap;
        bit                       calm;
    } t_job;

    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [1:0]               i_command = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;

    circular_queue_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_command  (i_command),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_job    job_backlog[$];
    t_answer awaited_answers[$];
    int      error_count = 0;

    // ring model
    logic signed [DATA_W-1:0] ring_words[DEPTH];
    int                       ring_head;
    int                       ring_tail;
    int                       ring_fill;
    logic [CFG_W-1:0]         ring_cap;

    bit gen_calm = 1'b0;
    bit calm_phase = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic int usable_slots();
        int n;
        n = ring_cap;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    function automatic int next_slot(input int idx);
        int n;
        n = idx + 1;
        return (n >= usable_slots()) ? 0 : n;
    endfunction

    task automatic add_answer(input logic [1:0] st, input logic signed [DATA_W-1:0] d,
                              input logic lst);
        t_answer a;
        a.status = st;
        a.data = d;
        a.last = lst;
        awaited_answers.push_back(a);
    endtask

    task automatic ring_apply(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
        int idx;
        if (cmd == OP_ENQ) begin
            if (ring_fill >= usable_slots()) begin
                add_answer(ST_FULL, '0, 1'b1);
            end else begin
                ring_words[ring_tail] = val;
                ring_tail = next_slot(ring_tail);
                ring_fill++;
                add_answer(ST_OK, '0, 1'b1);
            end
        end else if (cmd == OP_DEQ) begin
            if (ring_fill == 0) begin
                add_answer(ST_EMPTY, '0, 1'b1);
            end else begin
                add_answer(ST_OK, ring_words[ring_head], 1'b1);
                ring_head = next_slot(ring_head);
                ring_fill--;
            end
        end else if (cmd == OP_DISP) begin
            if (ring_fill == 0) begin
                add_answer(ST_EMPTY, '0, 1'b1);
            end else begin
                idx = ring_head;
                for (int k = 0; k < ring_fill; k++) begin
                    add_answer(ST_OK, ring_words[idx], k == ring_fill - 1);
                    idx = next_slot(idx);
                end
            end
        end
    endtask

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    // driver
    t_job nxt;
    logic next_push;
    logic next_we;
    int   gap_left = 0;
    int   settle_left = SETTLE;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left = 0;
            settle_left = SETTLE;
            ring_head = 0;
            ring_tail = 0;
            ring_fill = 0;
            ring_cap = 7'd64;
            for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
        end else begin
            next_push = push && full;
            next_we = 1'b0;
            if (push && !full) ring_apply(i_command, i_value);
            if (i_cfg_we) begin
                ring_cap = i_cfg_wdata;
                ring_head = 0;
                ring_tail = 0;
                ring_fill = 0;
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_backlog.size() > 0) begin
                    nxt = job_backlog[0];
                    if (nxt.kind == K_CMD) begin
                        i_command <= nxt.cmd;
                        i_value <= nxt.val;
                        next_push = 1'b1;
                        calm_phase = nxt.calm;
                        void'(job_backlog.pop_front());
                        if (!nxt.calm && job_backlog.size() >= QUIET_TAIL &&
                            $urandom_range(0, 5) == 0)
                            gap_left = $urandom_range(1, 11);
                    end else if (awaited_answers.size() == 0 && !i_cfg_we) begin
                        if (settle_left > 0) begin
                            settle_left--;
                        end else begin
                            settle_left = SETTLE;
                            if (nxt.kind == K_CFG) begin
                                i_cfg_wdata <= nxt.cap;
                                next_we = 1'b1;
                            end
                            void'(job_backlog.pop_front());
                        end
                    end else begin
                        settle_left = SETTLE;
                    end
                end
            end
            push <= next_push;
            i_cfg_we <= next_we;
        end
    end

    // monitor
    t_answer want;
    int      stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else begin
            if (pop && !empty) begin
                if (awaited_answers.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction status=%0d data=%0d last=%0d",
                                            o_status, o_data, o_last));
                end else begin
                    want = awaited_answers.pop_front();
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_data !== want.data)
                        flag_mismatch($sformatf("data %0d, want %0d", o_data, want.data));
                    if (o_last !== want.last)
                        flag_mismatch($sformatf("last %0d, want %0d", o_last, want.last));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (!calm_phase && job_backlog.size() >= QUIET_TAIL &&
                         $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 10);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic add_cmd(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
        t_job j;
        j.kind = K_CMD;
        j.cmd = cmd;
        j.val = val;
        j.cap = '0;
        j.calm = gen_calm;
        job_backlog.push_back(j);
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] cap);
        t_job j;
        j.kind = K_CFG;
        j.cmd = '0;
        j.val = '0;
        j.cap = cap;
        j.calm = gen_calm;
        job_backlog.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = K_DRAIN;
        j.cmd = '0;
        j.val = '0;
        j.cap = '0;
        j.calm = gen_calm;
        job_backlog.push_back(j);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_cap();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(65, 127));
            2: return CFG_W'(DEPTH);
            3, 4: return CFG_W'($urandom_range(1, 64));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic build_stimulus();
        int r;
        // empty queue, extremes, unused command
        add_cmd(OP_DEQ, 32'sh1234_5678);
        add_cmd(OP_DISP, '0);
        add_cmd(OP_ENQ, 32'sh8000_0000);
        add_cmd(OP_ENQ, 32'sh7fff_ffff);
        add_cmd(OP_ENQ, -32'sd1);
        add_cmd(CMD_UNUSED, 32'sh5555_aaaa);
        add_cmd(OP_DISP, '0);
        add_cmd(OP_DEQ, '0);
        // capacity 1, then 0 which behaves as 1
        add_cfg(7'd1);
        add_cmd(OP_ENQ, 32'sd17);
        add_cmd(OP_ENQ, 32'sd18);
        add_cmd(OP_DISP, '0);
        add_cmd(OP_DEQ, '0);
        add_cmd(OP_DEQ, '0);
        add_cfg(7'd0);
        add_cmd(OP_ENQ, 32'sh0f0f_0f0f);
        add_cmd(OP_ENQ, 32'sh7070_7070);
        // wrap-around walk at capacity 3
        add_cfg(7'd3);
        add_cmd(OP_ENQ, 32'sd1);
        add_cmd(OP_ENQ, 32'sd2);
        add_cmd(OP_ENQ, 32'sd3);
        add_cmd(OP_DEQ, '0);
        add_cmd(OP_ENQ, 32'sd4);
        add_cmd(OP_DISP, '0);
        add_cmd(OP_ENQ, 32'sd5);

        for (int p = 0; p < 6; p++) begin
            gen_calm = (p == 2);
            add_cfg(pick_cap());
            for (int n = 0; n < 3; n++) begin
                r = $urandom_range(0, 99);
                if (r < 50) add_cmd(OP_ENQ, pick_word());
                else if (r < 78) add_cmd(OP_DEQ, $urandom);
                else if (r < 95) add_cmd(OP_DISP, $urandom);
                else add_cmd(CMD_UNUSED, $urandom);
                if (p == 3 && n == 1) add_drain();
            end
        end

        // out-of-range capacity acts as full depth: fill, overflow, wrap, walk
        gen_calm = 1'b0;
        add_cfg(7'd127);
        for (int n = 0; n < DEPTH + 2; n++) add_cmd(OP_ENQ, pick_word());
        add_cmd(OP_DISP, '0);
        for (int n = 0; n < 3; n++) add_cmd(OP_DEQ, '0);
        for (int n = 0; n < 3; n++) add_cmd(OP_ENQ, pick_word());
        add_cmd(OP_DISP, '0);

        add_cfg(CFG_W'($urandom_range(2, 5)));
        for (int n = 0; n < 10; n++) begin
            r = $urandom_range(0, 99);
            if (r < 50) add_cmd(OP_ENQ, pick_word());
            else if (r < 80) add_cmd(OP_DEQ, '0);
            else add_cmd(OP_DISP, '0);
        end
    endtask

    initial begin
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (job_backlog.size() != 0 || push || i_cfg_we) @(posedge i_clk);
        while (awaited_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE * 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cqe_pkg.sv
rtl/cqe_ram.sv
rtl/cqe_front.sv
rtl/cqe_back.sv
rtl/circular_queue_engine.sv
tb/testbench.sv
